FILE: sv/rdpt_pkg.sv
// Shared types, constants and the phase route table for the rotor disk pulse tracker.
// No dependencies; every other file imports this package.
`default_nettype none

package rdpt_pkg;

  // Pulse counter width default (top-level parameter takes it).
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int SAMPLE_W   = 2;
  localparam int PHASE_W    = 4;
  localparam int PULSE_W    = 32;
  localparam int LEVEL_W    = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_SECTOR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIXED_RUN    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAL_CEIL    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_RUN     = 8'd3;

  // Register reset values.
  localparam logic [LEVEL_W-1:0] SHORT_SECTOR_RST = 8'd2;
  localparam logic [LEVEL_W-1:0] MIXED_LIMIT_RST  = 8'd16;
  localparam logic [LEVEL_W-1:0] QUAL_CEIL_RST    = 8'd255;
  localparam logic [LEVEL_W-1:0] ZERO_LIMIT_RST   = 8'd100;

  // Run counter restart values.
  localparam logic [LEVEL_W-1:0] SECTOR_RUN_RST = 8'd2;
  localparam logic [LEVEL_W-1:0] MIXED_RUN_RST  = 8'd1;

  // Phase codes: idle, then enter / continued / mixed / zero for each sector.
  localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
  localparam logic [PHASE_W-1:0] PH_S0_ENTER = 4'd1;
  localparam logic [PHASE_W-1:0] PH_S0_CONT  = 4'd2;
  localparam logic [PHASE_W-1:0] PH_S0_MIXED = 4'd3;
  localparam logic [PHASE_W-1:0] PH_S0_ZERO  = 4'd4;
  localparam logic [PHASE_W-1:0] PH_S1_ENTER = 4'd5;
  localparam logic [PHASE_W-1:0] PH_S1_CONT  = 4'd6;
  localparam logic [PHASE_W-1:0] PH_S1_MIXED = 4'd7;
  localparam logic [PHASE_W-1:0] PH_S1_ZERO  = 4'd8;

  localparam logic [1:0] ROW_IDLE = 2'd0;
  localparam logic [1:0] ROW_S0   = 2'd1;
  localparam logic [1:0] ROW_S1   = 2'd2;

  // Route table: row by phase group, column by sensor sample.
  localparam logic [PHASE_W-1:0] ROUTE [3][4] = '{
    '{PH_IDLE,    PH_S0_ENTER, PH_S1_ENTER, PH_IDLE},
    '{PH_S0_ZERO, PH_S0_CONT,  PH_S1_ENTER, PH_S0_MIXED},
    '{PH_S1_ZERO, PH_S0_ENTER, PH_S1_CONT,  PH_S1_MIXED}
  };

  typedef struct packed {
    logic [LEVEL_W-1:0] short_sector_limit;
    logic [LEVEL_W-1:0] mixed_run_limit;
    logic [LEVEL_W-1:0] quality_ceiling;
    logic [LEVEL_W-1:0] zero_run_limit;
  } cfg_regs_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [PULSE_W-1:0] pulse_count;
    logic [LEVEL_W-1:0] quality_level;
    logic               halted;
    logic               counted;
  } result_t;

  function automatic logic [1:0] route_row(input logic [PHASE_W-1:0] ph);
    logic [1:0] row;
    if (ph >= PH_S0_ENTER && ph <= PH_S0_ZERO) row = ROW_S0;
    else if (ph >= PH_S1_ENTER && ph <= PH_S1_ZERO) row = ROW_S1;
    else row = ROW_IDLE;
    return row;
  endfunction

  function automatic logic [PHASE_W-1:0] route_next(input logic [PHASE_W-1:0] ph,
                                                    input logic [SAMPLE_W-1:0] s);
    return ROUTE[route_row(ph)][s];
  endfunction

endpackage

`default_nettype wire

FILE: sv/rdpt_if.sv
// Valid/ready channel interfaces: sensor samples, result words, configuration writes.
// Depends on rdpt_pkg.
`default_nettype none

interface rdpt_sample_if;
  import rdpt_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sensor_bits;
  modport source (output valid, output sensor_bits, input ready);
  modport sink   (input valid, input sensor_bits, output ready);
endinterface

interface rdpt_result_if;
  import rdpt_pkg::*;
  logic               valid;
  logic               ready;
  logic [PHASE_W-1:0] phase;
  logic [PULSE_W-1:0] pulse_count;
  logic [LEVEL_W-1:0] quality_level;
  logic               halted;
  logic               counted;
  modport source (output valid, output phase, output pulse_count, output quality_level,
                  output halted, output counted, input ready);
  modport sink   (input valid, input phase, input pulse_count, input quality_level,
                  input halted, input counted, output ready);
endinterface

interface rdpt_cfg_if;
  import rdpt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/rdpt_core.sv
// Tracker state: phase, pulse total, run counters, quality and halt, with the
// per-sample update and the result word it produces. Depends on rdpt_pkg.
`default_nettype none

module rdpt_core #(
  parameter int COUNT_WIDTH = rdpt_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             step,
  input  wire logic [rdpt_pkg::SAMPLE_W-1:0]    sensor_bits,
  input  wire rdpt_pkg::cfg_regs_t              cfg_regs,
  output rdpt_pkg::result_t                     res_next
);
  import rdpt_pkg::*;

  logic [PHASE_W-1:0]     phase_reg,   phase_reg_next;
  logic [COUNT_WIDTH-1:0] pulse_total, pulse_total_next;
  logic [LEVEL_W-1:0]     zero_run,    zero_run_next;
  logic [LEVEL_W-1:0]     sector_run,  sector_run_next;
  logic [LEVEL_W-1:0]     mixed_run,   mixed_run_next;
  logic [LEVEL_W-1:0]     quality,     quality_next;
  logic                   halt_flag,   halt_flag_next;
  logic                   counted;

  // Mixed-run step, shared by the continued and mixed phases.
  logic [LEVEL_W-1:0] mix_run_step;
  logic [LEVEL_W-1:0] mix_qual_step;
  logic [LEVEL_W-1:0] sector_age;

  always_comb begin
    if (mixed_run < cfg_regs.mixed_run_limit) begin
      mix_run_step  = mixed_run + 8'd1;
      mix_qual_step = quality;
    end else begin
      mix_run_step  = MIXED_RUN_RST;
      mix_qual_step = (quality < cfg_regs.quality_ceiling) ? quality + 8'd1 : quality;
    end
  end

  assign sector_age = sector_run - 8'd1;

  always_comb begin
    phase_reg_next   = phase_reg;
    pulse_total_next = pulse_total;
    zero_run_next    = zero_run;
    sector_run_next  = sector_run;
    mixed_run_next   = mixed_run;
    quality_next     = quality;
    halt_flag_next   = halt_flag;
    counted          = 1'b0;
    if (!halt_flag) begin
      phase_reg_next = route_next(phase_reg, sensor_bits);
      case (phase_reg_next) inside
        PH_IDLE: begin
          zero_run_next   = '0;
          sector_run_next = SECTOR_RUN_RST;
          mixed_run_next  = MIXED_RUN_RST;
        end
        PH_S0_ENTER, PH_S1_ENTER: begin
          pulse_total_next = pulse_total + COUNT_WIDTH'(1);
          counted          = 1'b1;
          // Sector left too quickly: quality drops, floored at zero.
          if (sector_age < cfg_regs.short_sector_limit && quality != '0) begin
            quality_next = quality - 8'd1;
          end
          zero_run_next   = '0;
          sector_run_next = SECTOR_RUN_RST;
          mixed_run_next  = MIXED_RUN_RST;
        end
        PH_S0_CONT, PH_S1_CONT: begin
          // Sector run sticks at zero once it has wrapped.
          if (sector_run != '0) sector_run_next = sector_run + 8'd1;
          mixed_run_next = mix_run_step;
          quality_next   = mix_qual_step;
        end
        PH_S0_MIXED, PH_S1_MIXED: begin
          mixed_run_next = mix_run_step;
          quality_next   = mix_qual_step;
        end
        default: begin
          if (zero_run < cfg_regs.zero_run_limit) zero_run_next = zero_run + 8'd1;
          else halt_flag_next = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg   <= PH_IDLE;
      pulse_total <= '0;
      zero_run    <= '0;
      sector_run  <= SECTOR_RUN_RST;
      mixed_run   <= MIXED_RUN_RST;
      quality     <= '0;
      halt_flag   <= 1'b0;
    end else if (step) begin
      phase_reg   <= phase_reg_next;
      pulse_total <= pulse_total_next;
      zero_run    <= zero_run_next;
      sector_run  <= sector_run_next;
      mixed_run   <= mixed_run_next;
      quality     <= quality_next;
      halt_flag   <= halt_flag_next;
    end
  end

  always_comb begin
    res_next.phase         = phase_reg_next;
    res_next.pulse_count   = PULSE_W'(pulse_total_next);
    res_next.quality_level = quality_next;
    res_next.halted        = halt_flag_next;
    res_next.counted       = counted;
  end

  // Halt is sticky until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt_flag |=> halt_flag)
    else $error("halt flag dropped without reset");

  // Once halted, a sample changes nothing.
  a_halt_freezes: assert property (@(posedge clk) disable iff (rst)
    (step && halt_flag) |=> ($stable(phase_reg) && $stable(pulse_total) && $stable(quality)))
    else $error("state moved while halted");

  // A pulse is counted only on a sector entry.
  a_count_on_enter: assert property (@(posedge clk) disable iff (rst)
    res_next.counted |-> (res_next.phase == PH_S0_ENTER || res_next.phase == PH_S1_ENTER))
    else $error("pulse counted outside a sector entry");

  // No sample, no state change.
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !step |=> ($stable(phase_reg) && $stable(quality) && $stable(halt_flag)))
    else $error("state moved without a sample");

  // Phase stays within the nine route states.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase_reg <= PH_S1_ZERO)
    else $error("phase out of range");

endmodule

`default_nettype wire

FILE: sv/rotor_disk_pulse_tracker.sv
// Top level of the rotor disk pulse tracker: channel handshakes, configuration
// registers, input and result registers. Depends on rdpt_pkg, rdpt_if, rdpt_core.
//
//   channel  dir  word                                             handshake
//   -------  ---  -----------------------------------------------  ---------
//   sample   in   sensor_bits[1:0]                                 valid/ready
//   result   out  phase, pulse_count, quality_level, halted,       valid/ready
//                 counted
//   cfg      in   index[7:0], data[7:0]                            valid/ready
//
// One sample word per cycle, sustained while the result channel is not stalled. The
// sample is captured in the input register, the state update runs in one combinational
// pass from that register, and the result word lands in the output register.
// rst (synchronous) clears both register valids, the tracker state and the
// configuration registers to their defaults. A stalled result holds in the output
// register; while the output is full, the input register still takes a word if it is empty.
`default_nettype none

module rotor_disk_pulse_tracker #(
  parameter int COUNT_WIDTH = rdpt_pkg::COUNT_WIDTH_DEF
) (
  input wire logic       clk,
  input wire logic       rst,
  rdpt_sample_if.sink    sample,
  rdpt_result_if.source  result,
  rdpt_cfg_if.sink       cfg
);
  import rdpt_pkg::*;

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  cfg_regs_t cfg_regs;

  // Input register stage.
  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_bits;

  // Result register stage.
  logic    out_valid;
  result_t out_word;
  result_t res_next;

  logic advance;   // result register can take a new word this cycle
  logic step;      // the held sample is processed this cycle

  assign advance      = !out_valid || result.ready;
  assign step         = s1_valid && advance;
  assign sample.ready = !s1_valid || advance;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.short_sector_limit <= SHORT_SECTOR_RST;
      cfg_regs.mixed_run_limit    <= MIXED_LIMIT_RST;
      cfg_regs.quality_ceiling    <= QUAL_CEIL_RST;
      cfg_regs.zero_run_limit     <= ZERO_LIMIT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_SHORT_SECTOR: cfg_regs.short_sector_limit <= cfg.data;
        CFG_MIXED_RUN:    cfg_regs.mixed_run_limit    <= cfg.data;
        CFG_QUAL_CEIL:    cfg_regs.quality_ceiling    <= cfg.data;
        CFG_ZERO_RUN:     cfg_regs.zero_run_limit     <= cfg.data;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // Input register: refill on accept, drain when processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.valid && sample.ready) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) s1_bits <= sample.sensor_bits;
  end

  rdpt_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .sensor_bits (s1_bits),
    .cfg_regs    (cfg_regs),
    .res_next    (res_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_word <= res_next;
  end

  assign result.valid         = out_valid;
  assign result.phase         = out_word.phase;
  assign result.pulse_count   = out_word.pulse_count;
  assign result.quality_level = out_word.quality_level;
  assign result.halted        = out_word.halted;
  assign result.counted       = out_word.counted;

endmodule

`default_nettype wire

FILE: tb/rotor_disk_pulse_tracker_tb.sv
// Self-checking testbench for rotor_disk_pulse_tracker: sensor sample words in,
// tracker result words out. Depends on rdpt_pkg, the rdpt_sample_if /
// rdpt_result_if / rdpt_cfg_if interfaces and the RTL top.
module rotor_disk_pulse_tracker_tb;
  import rdpt_pkg::*;

  // Sensor patterns: bit0 is the first sensor, bit1 the second.
  localparam logic [SAMPLE_W-1:0] SMP_DARK   = 2'b00;
  localparam logic [SAMPLE_W-1:0] SMP_FIRST  = 2'b01;
  localparam logic [SAMPLE_W-1:0] SMP_SECOND = 2'b10;
  localparam logic [SAMPLE_W-1:0] SMP_BOTH   = 2'b11;

  // Cycles with no handshake on any channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 1000;
  // Length of the forced receiver hold-off that backs the block up.
  localparam int LONG_HOLD = 90;

  typedef enum {PACE_FLAT, PACE_RANDOM, PACE_BURSTY} pace_t;

  typedef struct {
    logic [SAMPLE_W-1:0] bits;
    int                  gap;    // idle cycles before this word is offered
    bit                  drain;  // hold this word until every result is back
  } sample_word_t;

  logic clk;
  logic rst;

  rdpt_sample_if sample_ch ();
  rdpt_result_if result_ch ();
  rdpt_cfg_if    cfg_ch ();

  rotor_disk_pulse_tracker dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Words waiting for the driver, and result words predicted but not yet seen.
  sample_word_t sensor_stream[$];
  result_t      predicted_words[$];

  int pushed_cnt   = 0;
  int accepted_cnt = 0;
  int checked_cnt  = 0;
  int fail_count   = 0;
  int hold_req     = 0;
  int hold_served  = 0;

  pace_t tx_pace;
  pace_t rx_pace;
  bit    drain_next = 1'b0;

  // Tracker state as the block should hold it.
  cfg_regs_t          trk_cfg;
  logic [PHASE_W-1:0] trk_phase;
  logic [PULSE_W-1:0] trk_pulses;
  logic [LEVEL_W-1:0] trk_zero_run;
  logic [LEVEL_W-1:0] trk_sector_run;
  logic [LEVEL_W-1:0] trk_mixed_run;
  logic [LEVEL_W-1:0] trk_quality;
  logic               trk_halt;

  // Stimulus side view of the phase, used to keep zero runs short of the halt
  // until the halt is wanted.
  logic [PHASE_W-1:0] gen_phase;
  int                 gen_zeros;
  int                 gen_zero_limit;
  bit                 zero_guard;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Next phase for a sample: idle row, sector s0 row, sector s1 row.
  function automatic logic [PHASE_W-1:0] route_of(input logic [PHASE_W-1:0] ph,
                                                  input logic [SAMPLE_W-1:0] s);
    logic [PHASE_W-1:0] nx;
    if (ph >= PH_S0_ENTER && ph <= PH_S0_ZERO) begin
      case (s)
        SMP_DARK:   nx = PH_S0_ZERO;
        SMP_FIRST:  nx = PH_S0_CONT;
        SMP_SECOND: nx = PH_S1_ENTER;
        default:    nx = PH_S0_MIXED;
      endcase
    end else if (ph >= PH_S1_ENTER && ph <= PH_S1_ZERO) begin
      case (s)
        SMP_DARK:   nx = PH_S1_ZERO;
        SMP_FIRST:  nx = PH_S0_ENTER;
        SMP_SECOND: nx = PH_S1_CONT;
        default:    nx = PH_S1_MIXED;
      endcase
    end else begin
      case (s)
        SMP_FIRST:  nx = PH_S0_ENTER;
        SMP_SECOND: nx = PH_S1_ENTER;
        default:    nx = PH_IDLE;
      endcase
    end
    return nx;
  endfunction

  function automatic int draw_wait(input pace_t pace);
    case (pace)
      PACE_FLAT:   return 0;
      PACE_RANDOM: return $urandom_range(0, 13);
      default:     return ($urandom_range(0, 5) == 0) ? $urandom_range(0, 13) : 0;
    endcase
  endfunction

  // Mixed run overflow raises quality, capped at the ceiling; a quality already
  // above a lowered ceiling is left alone.
  task automatic mixed_tick();
    if (trk_mixed_run < trk_cfg.mixed_run_limit) begin
      trk_mixed_run = trk_mixed_run + 8'd1;
    end else begin
      if (trk_quality < trk_cfg.quality_ceiling) trk_quality = trk_quality + 8'd1;
      trk_mixed_run = MIXED_RUN_RST;
    end
  endtask

  // Advance the tracker by one accepted sample and queue the result word it yields.
  task automatic track_sample(input logic [SAMPLE_W-1:0] bits);
    result_t            r;
    logic               hit;
    logic [LEVEL_W-1:0] run_len;
    hit = 1'b0;
    if (!trk_halt) begin
      trk_phase = route_of(trk_phase, bits);
      case (trk_phase)
        PH_IDLE: begin
          trk_zero_run   = '0;
          trk_sector_run = SECTOR_RUN_RST;
          trk_mixed_run  = MIXED_RUN_RST;
        end
        PH_S0_ENTER, PH_S1_ENTER: begin
          trk_pulses = trk_pulses + 1'b1;
          hit        = 1'b1;
          // leaving a sector too soon costs one quality step, floor at zero
          run_len = trk_sector_run - 8'd1;
          if (run_len < trk_cfg.short_sector_limit && trk_quality != '0)
            trk_quality = trk_quality - 8'd1;
          trk_zero_run   = '0;
          trk_sector_run = SECTOR_RUN_RST;
          trk_mixed_run  = MIXED_RUN_RST;
        end
        PH_S0_CONT, PH_S1_CONT: begin
          // a sector run that wrapped to zero sticks there
          if (trk_sector_run != '0) trk_sector_run = trk_sector_run + 8'd1;
          mixed_tick();
        end
        PH_S0_MIXED, PH_S1_MIXED: begin
          mixed_tick();
        end
        default: begin
          if (trk_zero_run < trk_cfg.zero_run_limit) trk_zero_run = trk_zero_run + 8'd1;
          else trk_halt = 1'b1;
        end
      endcase
    end
    r.phase         = trk_phase;
    r.pulse_count   = trk_pulses;
    r.quality_level = trk_quality;
    r.halted        = trk_halt;
    r.counted       = hit;
    predicted_words.push_back(r);
  endtask

  // Queue one sample word; with the guard on, a zero that would reach the halt is
  // swapped for a sector change.
  task automatic offer(input logic [SAMPLE_W-1:0] bits);
    sample_word_t       w;
    logic [PHASE_W-1:0] nx;
    nx = route_of(gen_phase, bits);
    if (zero_guard && (nx == PH_S0_ZERO || nx == PH_S1_ZERO) && gen_zeros >= gen_zero_limit) begin
      bits = (nx == PH_S0_ZERO) ? SMP_SECOND : SMP_FIRST;
      nx   = route_of(gen_phase, bits);
    end
    if (nx == PH_S0_ZERO || nx == PH_S1_ZERO) gen_zeros++;
    else if (nx == PH_IDLE || nx == PH_S0_ENTER || nx == PH_S1_ENTER) gen_zeros = 0;
    gen_phase  = nx;
    w.bits     = bits;
    w.gap      = draw_wait(tx_pace);
    w.drain    = drain_next;
    drain_next = 1'b0;
    sensor_stream.push_back(w);
    pushed_cnt++;
  endtask

  // One well-formed sector: the entering pattern, then mostly continuation with
  // mixed and (optionally) zero samples sprinkled in.
  task automatic spin_sector(input int body_len, input bit with_zeros);
    logic [SAMPLE_W-1:0] stay;
    int                  r;
    if (gen_phase >= PH_S0_ENTER && gen_phase <= PH_S0_ZERO) begin
      offer(SMP_SECOND);
      stay = SMP_SECOND;
    end else begin
      offer(SMP_FIRST);
      stay = SMP_FIRST;
    end
    repeat (body_len) begin
      r = $urandom_range(0, 9);
      if (r < 7) offer(stay);
      else if (r < 9 || !with_zeros) offer(SMP_BOTH);
      else offer(SMP_DARK);
    end
  endtask

  task automatic fill_random(input int count);
    int target;
    int pick;
    target = pushed_cnt + count;
    while (pushed_cnt < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 9) < 7) spin_sector($urandom_range(0, 6), 1'b1);
        else spin_sector($urandom_range(7, 40), 1'b1);
      end else if (pick < 88) begin
        // noise: any pattern, any order
        repeat ($urandom_range(1, 6)) offer(2'($urandom_range(0, 3)));
      end else if (pick < 93) begin
        // zero burst, at times long enough to hit the guard at the limit
        repeat ($urandom_range(1, gen_zero_limit + 2)) offer(SMP_DARK);
      end else begin
        repeat ($urandom_range(1, 20)) offer(SMP_BOTH);
      end
    end
  endtask

  // Wait until every queued word went in and every predicted word came out.
  task automatic settle();
    while (accepted_cnt != pushed_cnt || checked_cnt != accepted_cnt) @(posedge clk);
    @(posedge clk);
  endtask

  // Call at a rising edge with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_SHORT_SECTOR: trk_cfg.short_sector_limit = val;
      CFG_MIXED_RUN:    trk_cfg.mixed_run_limit    = val;
      CFG_QUAL_CEIL:    trk_cfg.quality_ceiling    = val;
      CFG_ZERO_RUN:     trk_cfg.zero_run_limit     = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] short_lim, input logic [7:0] mixed_lim,
                           input logic [7:0] ceil, input logic [7:0] zero_lim);
    settle();
    write_reg(CFG_SHORT_SECTOR, short_lim);
    write_reg(CFG_MIXED_RUN, mixed_lim);
    write_reg(CFG_QUAL_CEIL, ceil);
    write_reg(CFG_ZERO_RUN, zero_lim);
    gen_zero_limit = zero_lim;
  endtask

  // Driver: offers the head of sensor_stream after its gap; every accepted word
  // goes straight into the tracker prediction.
  always @(posedge clk) begin : drive
    sample_word_t nxt;
    int           gap_spent;
    if (rst) begin
      sample_ch.valid       <= 1'b0;
      sample_ch.sensor_bits <= '0;
      gap_spent = 0;
      // tracker prediction restarts with the block
      trk_phase      = PH_IDLE;
      trk_pulses     = '0;
      trk_zero_run   = '0;
      trk_sector_run = SECTOR_RUN_RST;
      trk_mixed_run  = MIXED_RUN_RST;
      trk_quality    = '0;
      trk_halt       = 1'b0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        track_sample(sample_ch.sensor_bits);
        accepted_cnt++;
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (sensor_stream.size() == 0) begin
          sample_ch.valid <= 1'b0;
        end else if (sensor_stream[0].drain && predicted_words.size() != 0) begin
          sample_ch.valid <= 1'b0;
        end else if (gap_spent < sensor_stream[0].gap) begin
          gap_spent++;
          sample_ch.valid <= 1'b0;
        end else begin
          nxt = sensor_stream.pop_front();
          sample_ch.valid       <= 1'b1;
          sample_ch.sensor_bits <= nxt.bits;
          gap_spent = 0;
        end
      end
    end
  end

  // Monitor: random per-word stalls, plus the one long hold-off on request.
  always @(posedge clk) begin : observe
    result_t want;
    result_t got;
    int      stall_left;
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        checked_cnt++;
        got.phase         = result_ch.phase;
        got.pulse_count   = result_ch.pulse_count;
        got.quality_level = result_ch.quality_level;
        got.halted        = result_ch.halted;
        got.counted       = result_ch.counted;
        if (predicted_words.size() == 0) begin
          $error("result word with nothing predicted: phase %0d count %0d",
                 got.phase, got.pulse_count);
          fail_count++;
        end else begin
          want = predicted_words.pop_front();
          if (got.phase !== want.phase) begin
            $error("phase: expected %0d, got %0d", want.phase, got.phase);
            fail_count++;
          end
          if (got.pulse_count !== want.pulse_count) begin
            $error("pulse_count: expected %0d, got %0d", want.pulse_count, got.pulse_count);
            fail_count++;
          end
          if (got.quality_level !== want.quality_level) begin
            $error("quality_level: expected %0d, got %0d", want.quality_level,
                   got.quality_level);
            fail_count++;
          end
          if (got.halted !== want.halted) begin
            $error("halted: expected %0d, got %0d", want.halted, got.halted);
            fail_count++;
          end
          if (got.counted !== want.counted) begin
            $error("counted: expected %0d, got %0d", want.counted, got.counted);
            fail_count++;
          end
        end
        stall_left = draw_wait(rx_pace);
      end
      if (hold_served != hold_req) begin
        hold_served = hold_req;
        stall_left  = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [SAMPLE_W-1:0] opening [12];
    rst          = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;

    trk_cfg        = '{SHORT_SECTOR_RST, MIXED_LIMIT_RST, QUAL_CEIL_RST, ZERO_LIMIT_RST};
    gen_phase      = PH_IDLE;
    gen_zeros      = 0;
    gen_zero_limit = ZERO_LIMIT_RST;
    zero_guard     = 1'b1;
    tx_pace        = PACE_RANDOM;
    rx_pace        = PACE_RANDOM;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed walk at reset settings: idle on dark and on both, enter s0, continue,
    // mix, zero, cross to s1 and walk it, cross back, then an immediate cross
    // (short sector with quality already at zero).
    opening = '{SMP_DARK, SMP_BOTH, SMP_FIRST, SMP_FIRST, SMP_BOTH, SMP_DARK,
                SMP_SECOND, SMP_SECOND, SMP_BOTH, SMP_DARK, SMP_FIRST, SMP_SECOND};
    foreach (opening[k]) offer(opening[k]);
    // sixteen mixed samples overflow the mixed run once, then a fast exit takes it back
    repeat (16) offer(SMP_BOTH);
    offer(SMP_FIRST);

    // Fast quality rise toward its top, never lowered; longest zero run allowed.
    // The long hold-off lands here while the sender streams in bursts.
    configure(8'd0, 8'd1, 8'd255, 8'd255);
    tx_pace = PACE_BURSTY;
    rx_pace = PACE_FLAT;
    fill_random(260);
    hold_req++;

    // Ceiling drops below the current quality; nearly every exit counts as fast.
    // Midway the sender waits for the block to empty.
    configure(8'd254, 8'd255, 8'd5, 8'd60);
    tx_pace = PACE_RANDOM;
    rx_pace = PACE_RANDOM;
    fill_random(120);
    drain_next = 1'b1;
    fill_random(130);

    configure(8'd10, 8'd1, 8'd2, 8'd40);
    tx_pace = PACE_FLAT;
    rx_pace = PACE_BURSTY;
    fill_random(160);

    // Short limit at 255 plus one sector long enough for its run counter to wrap.
    configure(8'd255, 8'd4, 8'd0, 8'd30);
    tx_pace = PACE_BURSTY;
    rx_pace = PACE_BURSTY;
    fill_random(50);
    spin_sector(380, 1'b0);
    spin_sector(2, 1'b1);
    fill_random(50);

    configure(8'd3, 8'd8, 8'd200, 8'd20);
    tx_pace = PACE_RANDOM;
    rx_pace = PACE_RANDOM;
    fill_random(160);

    configure(8'($urandom_range(0, 254)), 8'($urandom_range(1, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(8, 255)));
    tx_pace = PACE_BURSTY;
    rx_pace = PACE_RANDOM;
    fill_random(110);

    // Halt: no zero sample tolerated, one zero inside a sector stops the tracker,
    // everything after is ignored.
    configure(8'd2, 8'd16, 8'd255, 8'd0);
    zero_guard = 1'b0;
    spin_sector(0, 1'b0);
    offer(SMP_DARK);
    fill_random(25);

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: rotor_disk_pulse_tracker.f
sv/rdpt_pkg.sv
sv/rdpt_if.sv
sv/rdpt_core.sv
sv/rotor_disk_pulse_tracker.sv
tb/rotor_disk_pulse_tracker_tb.sv
